### hdl/color_matrix_transform_core_defines.svh
// Assertion macros for the color matrix transform core.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef COLOR_MATRIX_TRANSFORM_CORE_DEFINES_SVH
`define COLOR_MATRIX_TRANSFORM_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define CMT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CMT_ASSERT_SAME(lbl, ante, cons, msg)
`define CMT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/cmt_pkg.sv
package cmt_pkg;

  localparam int unsigned NumChannels = 3;
  localparam int unsigned PixelWidth  = 16;
  localparam int unsigned FlagWidth   = 8;
  localparam int unsigned WeightWidth = 16;
  localparam int unsigned RowWidth    = 64;
  localparam int unsigned CfgIdxWidth = 3;

  // product of a 17-bit signed pixel and a 16-bit signed weight
  localparam int unsigned ProdWidth   = 33;
  // offset weight times 1.0 in Q8.8
  localparam int unsigned OffWidth    = 24;
  // three products plus the offset term, with headroom
  localparam int unsigned SumWidth    = 35;

  localparam int unsigned FracShift   = 12;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgRedWeights   = 3'd0,
    CfgGreenWeights = 3'd1,
    CfgBlueWeights  = 3'd2,
    CfgUseOffset    = 3'd3,
    CfgTruncMask    = 3'd4
  } cfg_reg_e;

  localparam logic [RowWidth-1:0] RedWeightsRst   = 64'h0000_0000_0000_1000;
  localparam logic [RowWidth-1:0] GreenWeightsRst = 64'h0000_0000_1000_0000;
  localparam logic [RowWidth-1:0] BlueWeightsRst  = 64'h0000_1000_0000_0000;
  localparam logic [FlagWidth-1:0] TruncMaskRst   = 8'h01;

endpackage

### hdl/color_matrix_transform_core.sv
// Path: an accepted pixel passes the stage-one, stage-two and output registers before the done_o strobe.
// Throughput: one pixel per cycle; busy_o stays low, start may be held every cycle.
// Stages: products, per-channel sum, round/clamp; the 17x16 multipliers set stage one.
// Reset: async active low; clears pipeline valids and loads identity weights,
// offset off and a truncation mask of 1. Results cannot be held off by the receiver.
`include "color_matrix_transform_core_defines.svh"

module color_matrix_transform_core import cmt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [RowWidth-1:0]    cfg_data_i,

  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [PixelWidth-1:0]  red_in_i,
  input  logic [PixelWidth-1:0]  green_in_i,
  input  logic [PixelWidth-1:0]  blue_in_i,
  input  logic [FlagWidth-1:0]   red_flags_in_i,
  input  logic [FlagWidth-1:0]   green_flags_in_i,
  input  logic [FlagWidth-1:0]   blue_flags_in_i,

  output logic                   done_o,
  output logic [PixelWidth-1:0]  red_out_o,
  output logic [PixelWidth-1:0]  green_out_o,
  output logic [PixelWidth-1:0]  blue_out_o,
  output logic [FlagWidth-1:0]   red_flags_out_o,
  output logic [FlagWidth-1:0]   green_flags_out_o,
  output logic [FlagWidth-1:0]   blue_flags_out_o,
  output logic [FlagWidth-1:0]   pixel_flags_out_o
);

  // configuration registers
  logic [RowWidth-1:0]  weights_q [NumChannels];
  logic                 use_offset_q;
  logic [FlagWidth-1:0] trunc_mask_q;
  logic                 cfg_we;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q[0] <= RedWeightsRst;
      weights_q[1] <= GreenWeightsRst;
      weights_q[2] <= BlueWeightsRst;
      use_offset_q <= 1'b0;
      trunc_mask_q <= TruncMaskRst;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgRedWeights:   weights_q[0] <= cfg_data_i;
        CfgGreenWeights: weights_q[1] <= cfg_data_i;
        CfgBlueWeights:  weights_q[2] <= cfg_data_i;
        CfgUseOffset:    use_offset_q <= cfg_data_i[0];
        CfgTruncMask:    trunc_mask_q <= cfg_data_i[FlagWidth-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start_i && !busy_o;

  // stage 1: nine products and three offset terms
  logic [PixelWidth-1:0]         px      [NumChannels];
  logic [FlagWidth-1:0]          flags_in[NumChannels];
  logic signed [ProdWidth-1:0]   prod_d  [NumChannels][NumChannels];
  logic signed [ProdWidth-1:0]   prod_q  [NumChannels][NumChannels];
  logic signed [OffWidth-1:0]    off_d   [NumChannels];
  logic signed [OffWidth-1:0]    off_q   [NumChannels];
  logic [FlagWidth-1:0]          flags1_q[NumChannels];
  logic                          v1_q;

  assign px[0]       = red_in_i;
  assign px[1]       = green_in_i;
  assign px[2]       = blue_in_i;
  assign flags_in[0] = red_flags_in_i;
  assign flags_in[1] = green_flags_in_i;
  assign flags_in[2] = blue_flags_in_i;

  always_comb begin
    for (int c = 0; c < NumChannels; c++) begin
      for (int k = 0; k < NumChannels; k++) begin
        prod_d[c][k] = $signed({1'b0, px[k]}) *
                       $signed(weights_q[c][k*WeightWidth +: WeightWidth]);
      end
      // offset weight times 1.0 in Q8.8 is a left shift by eight
      if (use_offset_q) begin
        off_d[c] = {$signed(weights_q[c][3*WeightWidth +: WeightWidth]), 8'h00};
      end else begin
        off_d[c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q   <= prod_d;
      off_q    <= off_d;
      flags1_q <= flags_in;
    end
  end

  // stage 2: per-channel sum
  logic signed [SumWidth-1:0] sum_d    [NumChannels];
  logic signed [SumWidth-1:0] sum_q    [NumChannels];
  logic [FlagWidth-1:0]       flags2_q [NumChannels];
  logic                       v2_q;

  always_comb begin
    for (int c = 0; c < NumChannels; c++) begin
      sum_d[c] = SumWidth'(prod_q[c][0]) + SumWidth'(prod_q[c][1])
               + SumWidth'(prod_q[c][2]) + SumWidth'(off_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      sum_q    <= sum_d;
      flags2_q <= flags1_q;
    end
  end

  // stage 3: round half up, clamp, mark flags
  logic [SumWidth-2:0]   rnd      [NumChannels];
  logic [PixelWidth-1:0] val_d    [NumChannels];
  logic [FlagWidth-1:0]  flg_d    [NumChannels];
  logic [PixelWidth-1:0] val_q    [NumChannels];
  logic [FlagWidth-1:0]  flg_q    [NumChannels];
  logic                  done_q;

  always_comb begin
    for (int c = 0; c < NumChannels; c++) begin
      rnd[c] = sum_q[c][SumWidth-2:0] + (SumWidth-1)'(1 << (FracShift - 1));
      if (sum_q[c][SumWidth-1]) begin
        val_d[c] = '0;
        flg_d[c] = flags2_q[c] | trunc_mask_q;
      end else if (|rnd[c][SumWidth-2:FracShift+PixelWidth]) begin
        val_d[c] = '1;
        flg_d[c] = flags2_q[c] | trunc_mask_q;
      end else begin
        val_d[c] = rnd[c][FracShift +: PixelWidth];
        flg_d[c] = flags2_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      val_q <= val_d;
      flg_q <= flg_d;
    end
  end

  // valid bits travel with the words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  assign done_o            = done_q;
  assign red_out_o         = val_q[0];
  assign green_out_o       = val_q[1];
  assign blue_out_o        = val_q[2];
  assign red_flags_out_o   = flg_q[0];
  assign green_flags_out_o = flg_q[1];
  assign blue_flags_out_o  = flg_q[2];
  assign pixel_flags_out_o = flg_q[0] | flg_q[1] | flg_q[2];

  `CMT_ASSERT_NEXT(a_accept_to_s1, accept, v1_q, "accepted word missing from stage one")
  `CMT_ASSERT_NEXT(a_s1_to_s2, v1_q, v2_q, "word dropped between stage one and two")
  `CMT_ASSERT_NEXT(a_s2_to_done, v2_q, done_o, "word dropped before the output")
  `CMT_ASSERT_NEXT(a_no_spurious, !v2_q, !done_o, "done strobe without a word in flight")

endmodule

### tb/tb_color_matrix_transform_core.sv
module tb_color_matrix_transform_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cmt_pkg::*;

  typedef struct packed {
    logic [PixelWidth-1:0] red;
    logic [PixelWidth-1:0] green;
    logic [PixelWidth-1:0] blue;
    logic [FlagWidth-1:0]  red_flags;
    logic [FlagWidth-1:0]  green_flags;
    logic [FlagWidth-1:0]  blue_flags;
  } pixel_t;

  typedef struct packed {
    logic [PixelWidth-1:0] red;
    logic [PixelWidth-1:0] green;
    logic [PixelWidth-1:0] blue;
    logic [FlagWidth-1:0]  red_flags;
    logic [FlagWidth-1:0]  green_flags;
    logic [FlagWidth-1:0]  blue_flags;
    logic [FlagWidth-1:0]  pixel_flags;
  } corrected_t;

  localparam longint Q88One     = 256;
  localparam longint RoundHalf  = longint'(1) << (FracShift - 1);
  localparam longint PixelMax   = (longint'(1) << PixelWidth) - 1;
  localparam int     MaxReports = 40;
  localparam int     MaxGap     = 18;

  class ccm_checker;
    logic [RowWidth-1:0]  rows [NumChannels];
    bit                   offset_on;
    logic [FlagWidth-1:0] trunc_mask;
    corrected_t           expected_q [$];
    int unsigned          mismatches;

    function new();
      rows[0]    = RedWeightsRst;
      rows[1]    = GreenWeightsRst;
      rows[2]    = BlueWeightsRst;
      offset_on  = 1'b0;
      trunc_mask = TruncMaskRst;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [RowWidth-1:0] data);
      case (idx)
        CfgRedWeights:   rows[0] = data;
        CfgGreenWeights: rows[1] = data;
        CfgBlueWeights:  rows[2] = data;
        CfgUseOffset:    offset_on = data[0];
        CfgTruncMask:    trunc_mask = data[FlagWidth-1:0];
        default: ;
      endcase
    endfunction

    function void correct_channel(logic [RowWidth-1:0] row, pixel_t p,
                                  logic [FlagWidth-1:0] flags_in,
                                  output logic [PixelWidth-1:0] level,
                                  output logic [FlagWidth-1:0] flags);
      logic [PixelWidth-1:0]         px [NumChannels];
      logic signed [WeightWidth-1:0] w;
      longint                        acc;
      longint                        rounded;
      px[0] = p.red;
      px[1] = p.green;
      px[2] = p.blue;
      acc = 0;
      for (int k = 0; k < NumChannels; k++) begin
        w = row[WeightWidth*k +: WeightWidth];
        acc += longint'(px[k]) * longint'(w);
      end
      if (offset_on) begin
        w = row[RowWidth-1 -: WeightWidth];
        acc += Q88One * longint'(w);
      end
      flags = flags_in;
      if (acc < 0) begin
        level = '0;
        flags |= trunc_mask;
      end else begin
        rounded = (acc + RoundHalf) >>> FracShift;
        if (rounded > PixelMax) begin
          rounded = PixelMax;
          flags |= trunc_mask;
        end
        level = rounded[PixelWidth-1:0];
      end
    endfunction

    function void note_pixel(pixel_t p);
      corrected_t r;
      correct_channel(rows[0], p, p.red_flags, r.red, r.red_flags);
      correct_channel(rows[1], p, p.green_flags, r.green, r.green_flags);
      correct_channel(rows[2], p, p.blue_flags, r.blue, r.blue_flags);
      r.pixel_flags = r.red_flags | r.green_flags | r.blue_flags;
      expected_q.push_back(r);
    endfunction

    function void report_field(string field, logic [PixelWidth-1:0] want,
                               logic [PixelWidth-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_pixel(corrected_t got);
      corrected_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t unexpected word: expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      report_field("red_out", want.red, got.red);
      report_field("green_out", want.green, got.green);
      report_field("blue_out", want.blue, got.blue);
      report_field("red_flags_out", PixelWidth'(want.red_flags),
                   PixelWidth'(got.red_flags));
      report_field("green_flags_out", PixelWidth'(want.green_flags),
                   PixelWidth'(got.green_flags));
      report_field("blue_flags_out", PixelWidth'(want.blue_flags),
                   PixelWidth'(got.blue_flags));
      report_field("pixel_flags_out", PixelWidth'(want.pixel_flags),
                   PixelWidth'(got.pixel_flags));
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [RowWidth-1:0]    cfg_data_i  = '0;
  logic                   start_i     = 1'b0;
  logic                   busy_o;
  pixel_t                 drv_pixel   = '0;
  logic                   done_o;
  corrected_t             dut_pixel;
  bit                     burst       = 1'b0;

  ccm_checker ccm = new();

  always #2 clk_i = ~clk_i;

  color_matrix_transform_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .red_in_i          (drv_pixel.red),
    .green_in_i        (drv_pixel.green),
    .blue_in_i         (drv_pixel.blue),
    .red_flags_in_i    (drv_pixel.red_flags),
    .green_flags_in_i  (drv_pixel.green_flags),
    .blue_flags_in_i   (drv_pixel.blue_flags),
    .done_o            (done_o),
    .red_out_o         (dut_pixel.red),
    .green_out_o       (dut_pixel.green),
    .blue_out_o        (dut_pixel.blue),
    .red_flags_out_o   (dut_pixel.red_flags),
    .green_flags_out_o (dut_pixel.green_flags),
    .blue_flags_out_o  (dut_pixel.blue_flags),
    .pixel_flags_out_o (dut_pixel.pixel_flags)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) ccm.note_pixel(drv_pixel);
      if (done_o) ccm.check_pixel(dut_pixel);
    end
  end

  function automatic int unsigned draw_gap();
    return burst ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic pixel_t make_pixel(logic [PixelWidth-1:0] r, g, b,
                                        logic [FlagWidth-1:0] rf, gf, bf);
    pixel_t p;
    p = '{red: r, green: g, blue: b, red_flags: rf, green_flags: gf, blue_flags: bf};
    return p;
  endfunction

  function automatic logic [PixelWidth-1:0] random_level();
    case ($urandom_range(0, 3))
      0:       return PixelWidth'($urandom_range(0, 16'hFFFF));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2:       return PixelWidth'($urandom_range(0, 16'h01FF));
      default: return PixelWidth'($urandom_range(16'h4000, 16'hC000));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    return make_pixel(random_level(), random_level(), random_level(),
                      FlagWidth'($urandom_range(0, 255)), FlagWidth'($urandom_range(0, 255)),
                      FlagWidth'($urandom_range(0, 255)));
  endfunction

  function automatic logic [WeightWidth-1:0] random_weight();
    logic [WeightWidth-1:0] mag;
    case ($urandom_range(0, 5))
      0: return WeightWidth'($urandom_range(0, 16'hFFFF));
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return '0;
      default: begin
        // at most 1.25 times unity gain in magnitude so that outputs stay in range more often
        mag = WeightWidth'($urandom_range(0, 16'h1400));
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic logic [RowWidth-1:0] random_row();
    return {random_weight(), random_weight(), random_weight(), random_weight()};
  endfunction

  // hold valid across back-to-back words; apply_settings drops it once the set is loaded
  task automatic write_reg(cfg_reg_e idx, logic [RowWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    ccm.set_reg(idx, data);
  endtask

  task automatic apply_settings(logic [RowWidth-1:0] red_row, green_row, blue_row,
                                bit offset_on, logic [FlagWidth-1:0] mask);
    write_reg(CfgRedWeights, red_row);
    write_reg(CfgGreenWeights, green_row);
    write_reg(CfgBlueWeights, blue_row);
    write_reg(CfgUseOffset, RowWidth'(offset_on));
    write_reg(CfgTruncMask, RowWidth'(mask));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(pixel_t p);
    int unsigned gap;
    gap = draw_gap();
    start_i   <= 1'b1;
    drv_pixel <= p;
    do @(posedge clk_i); while (busy_o);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (ccm.expected_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n_items;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity weights straight out of reset
    send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(16'h1234, 16'h8000, 16'h00FF, 8'h01, 8'h80, 8'h55));
    wait_idle();

    // half weight rounds up, all-negative row clamps to zero, large row
    // saturates; the offset weight is loaded but must be ignored
    apply_settings({16'h7FFF, 16'h0000, 16'h0000, 16'h0800},
                   {16'h8000, 16'h8000, 16'h8000, 16'h8000},
                   {16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, 8'hFF);
    send_pixel(make_pixel(16'h0001, 16'h0001, 16'h0001, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(16'h0003, 16'h0002, 16'h0001, 8'h0F, 8'hF0, 8'h3C));
    send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(16'h0100, 16'h0000, 16'hFFFF, 8'hAA, 8'h55, 8'h00));
    wait_idle();

    // offset on: most negative and most positive offsets, a weight just below one half,
    // empty mask
    apply_settings({16'h8000, 16'h1000, 16'h1000, 16'h1000},
                   {16'h7FFF, 16'h0000, 16'h0000, 16'h0000},
                   {16'h0001, 16'h0000, 16'h0000, 16'h07FF}, 1'b1, 8'h00);
    send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(16'h0001, 16'h0000, 16'h0000, 8'h12, 8'h34, 8'h56));
    send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(16'h4000, 16'h3000, 16'h2000, 8'h80, 8'h01, 8'h00));
    wait_idle();

    // negative unity gain and negative offset
    apply_settings({16'h0000, 16'h0000, 16'h0000, 16'hF000},
                   {16'hF000, 16'h0000, 16'h0000, 16'h1000},
                   {16'h0000, 16'h1000, 16'h1000, 16'h1000}, 1'b1, 8'hA5);
    send_pixel(make_pixel(16'h0080, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(16'h0200, 16'h1000, 16'h0010, 8'h00, 8'h5A, 8'h00));
    send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(16'h0000, 16'h0001, 16'h0000, 8'h01, 8'h02, 8'h04));
    wait_idle();

    for (int ph = 0; ph < 24; ph++) begin
      burst = ($urandom_range(0, 3) == 0);
      apply_settings(random_row(), random_row(), random_row(), 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
      n_items = $urandom_range(40, 64);
      for (int i = 0; i < n_items; i++) begin
        // let the pipeline run dry once in mid stream
        if (ph == 2 && i == n_items / 2) wait_idle();
        send_pixel(random_pixel());
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (ccm.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
